// ===== sv/dtb_pkg.sv =====
// Package for the decimating trace buffer.
// Holds command and register codes and the skip doubling rule; no dependencies.
`default_nettype none

package dtb_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] cfg_index_t;
  typedef logic [31:0] skip_t;

  localparam cmd_t CMD_SAMPLE  = 2'd0;
  localparam cmd_t CMD_RESTART = 2'd1;
  localparam cmd_t CMD_READ    = 2'd2;

  localparam cfg_index_t CFG_ENABLED    = 2'd0;
  localparam cfg_index_t CFG_AUTO_SKIP  = 2'd1;
  localparam cfg_index_t CFG_START_SKIP = 2'd2;
  localparam cfg_index_t CFG_EMPTY_CODE = 2'd3;

  localparam skip_t SKIP_TOP  = 32'h8000_0000;
  localparam skip_t SKIP_HALF = 32'h4000_0000;

  function automatic skip_t doubled_skip(input skip_t s);
    skip_t r;
    if (s == '0) begin
      r = 32'd1;
    end else if (s >= SKIP_TOP) begin
      r = s;
    end else if (s >= SKIP_HALF) begin
      r = SKIP_TOP;
    end else begin
      r = {s[30:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/decimating_trace_buffer_core.sv =====
// Top level of the decimating trace buffer: control sequencer and the entry memory.
// Depends on dtb_pkg for command codes, register indexes and the skip rule.
//
// Usage: items arrive on the in_ channel (cmd, x_word, y_word, read_index) and each
// item yields exactly one result item on the out_ channel. An item is taken when
// in_valid is high and in_stall is low; a result is taken when out_valid is high and
// out_stall is low. Configuration is written through cfg_write, cfg_index, cfg_data.
// A sample, a read or an ignored command moves the sequencer to its done state; the
// result is loaded into the output register as it returns to idle for the next item.
// A read uses the registered read port of the entry memory.
// A restart sweeps the memory with the empty code, one row per cycle.
// A sample that fills the store in auto mode compacts it: the sequencer copies row
// 2i to row i, then fills the upper rows.
// After reset the memory is cleared to zero in a pass over every row during which
// in_stall is high; configuration writes are taken throughout.
// When the receiver stalls, the result is held in the output register; the block
// still takes the next item and finishes it, then waits until the register is free.
`default_nettype none

module decimating_trace_buffer_core #(
  parameter int ROWS       = 1024,
  parameter int WORD_WIDTH = 32
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_write,
  input  wire  [1:0]            cfg_index,
  input  wire  [31:0]           cfg_data,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire  [1:0]            cmd,
  input  wire  [31:0]           x_word,
  input  wire  [31:0]           y_word,
  input  wire  [9:0]            read_index,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [31:0]           read_x,
  output logic [31:0]           read_y,
  output logic [9:0]            write_index,
  output logic [31:0]           skip_now,
  output logic                  compacted
);

  localparam int ROW_W = $clog2(ROWS);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0] HALF_ROW  = ROW_W'((ROWS - 1) / 2);
  localparam logic [ROW_W-1:0] HALF_NEXT = ROW_W'((ROWS - 1) / 2 + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PACK,
    ST_FILL,
    ST_CLEAR,
    ST_DONE
  } state_t;

  state_t state;

  logic                  enabled;
  logic                  auto_skip;
  dtb_pkg::skip_t        start_skip;
  logic [WORD_WIDTH-1:0] empty_code;

  logic [ROW_W-1:0]      write_row;
  dtb_pkg::skip_t        skip_value;
  dtb_pkg::skip_t        skip_counter;
  logic [ROW_W-1:0]      idx;
  logic [WORD_WIDTH-1:0] fill_code;
  logic                  mark_pending;
  logic                  clear_result;
  logic                  res_read;
  logic                  res_packed;

  logic [2*WORD_WIDTH-1:0] entries [ROWS];
  logic [2*WORD_WIDTH-1:0] entry_q;
  logic                    mem_we;
  logic [ROW_W-1:0]        mem_waddr;
  logic [2*WORD_WIDTH-1:0] mem_wdata;
  logic                    mem_re;
  logic [ROW_W-1:0]        mem_raddr;

  logic             accept;
  logic             keep;
  logic [ROW_W:0]   row_inc;
  logic             row_full;
  logic             read_in_range;
  logic             out_free;

  assign in_stall      = rst || (state != ST_IDLE);
  assign accept        = in_valid && !in_stall;
  assign keep          = (skip_counter == '0) || (skip_counter > skip_value);
  assign row_inc       = {1'b0, write_row} + 1'b1;
  assign row_full      = row_inc >= {1'b0, LAST_ROW};
  assign read_in_range = {22'd0, read_index} < 32'(ROWS);
  assign out_free      = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled    <= 1'b1;
      auto_skip  <= 1'b0;
      start_skip <= '0;
      empty_code <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dtb_pkg::CFG_ENABLED:    enabled    <= cfg_data[0];
        dtb_pkg::CFG_AUTO_SKIP:  auto_skip  <= cfg_data[0];
        dtb_pkg::CFG_START_SKIP: start_skip <= cfg_data;
        dtb_pkg::CFG_EMPTY_CODE: empty_code <= WORD_WIDTH'(cfg_data);
      endcase
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = write_row;
    mem_wdata = {empty_code, empty_code};
    mem_re    = 1'b0;
    mem_raddr = ROW_W'(read_index);
    unique case (state)
      ST_IDLE: begin
        if (accept && enabled && (cmd == dtb_pkg::CMD_SAMPLE) && keep) begin
          mem_we    = 1'b1;
          mem_wdata = {WORD_WIDTH'(x_word), WORD_WIDTH'(y_word)};
        end
        if (accept && (cmd == dtb_pkg::CMD_READ)) begin
          mem_re = 1'b1;
        end
      end
      ST_PACK: begin
        mem_re    = idx <= HALF_ROW;
        mem_raddr = ROW_W'({idx, 1'b0});
        mem_we    = idx != '0;
        mem_waddr = idx - 1'b1;
        mem_wdata = entry_q;
      end
      ST_FILL, ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = {fill_code, fill_code};
      end
      ST_DONE: begin
        mem_we = mark_pending;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entries[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      entry_q <= entries[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      idx          <= '0;
      fill_code    <= '0;
      write_row    <= '0;
      skip_value   <= '0;
      skip_counter <= '0;
      mark_pending <= 1'b0;
      clear_result <= 1'b0;
      res_read     <= 1'b0;
      res_packed   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state        <= ST_DONE;
            mark_pending <= 1'b0;
            res_read     <= (cmd == dtb_pkg::CMD_READ) && read_in_range;
            res_packed   <= 1'b0;
            if (enabled && (cmd == dtb_pkg::CMD_SAMPLE)) begin
              skip_counter <= keep ? 32'd1 : skip_counter + 1'b1;
              if (keep) begin
                mark_pending <= 1'b1;
                if (!row_full) begin
                  write_row <= row_inc[ROW_W-1:0];
                end else if (auto_skip) begin
                  state      <= ST_PACK;
                  idx        <= '0;
                  fill_code  <= empty_code;
                  write_row  <= HALF_ROW;
                  skip_value <= dtb_pkg::doubled_skip(skip_value);
                  res_packed <= 1'b1;
                end else begin
                  write_row <= '0;
                end
              end
            end else if (enabled && (cmd == dtb_pkg::CMD_RESTART)) begin
              state        <= ST_CLEAR;
              idx          <= '0;
              fill_code    <= empty_code;
              write_row    <= '0;
              skip_value   <= start_skip;
              skip_counter <= '0;
              clear_result <= 1'b1;
            end
          end
        end
        ST_PACK: begin
          if (idx == HALF_NEXT) begin
            state <= ST_FILL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_FILL: begin
          if (idx == LAST_ROW) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_CLEAR: begin
          if (idx == LAST_ROW) begin
            state <= clear_result ? ST_DONE : ST_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        ST_DONE: begin
          mark_pending <= 1'b0;
          if (out_free) begin
            state       <= ST_IDLE;
            out_valid   <= 1'b1;
            read_x      <= res_read ? 32'(entry_q[2*WORD_WIDTH-1:WORD_WIDTH]) : '0;
            read_y      <= res_read ? 32'(entry_q[WORD_WIDTH-1:0]) : '0;
            write_index <= 10'(write_row);
            skip_now    <= skip_value;
            compacted   <= res_packed;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/dtb_checker.sv =====
// Port-level checker for decimating_trace_buffer_core, attached by a bind statement.
// Uses only the top-level ports; no package dependencies.
`default_nettype none

module dtb_checker #(
  parameter int ROWS = 1024
) (
  input wire        clk,
  input wire        rst,
  input wire        in_valid,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [31:0] read_x,
  input wire [31:0] read_y,
  input wire [9:0]  write_index,
  input wire [31:0] skip_now,
  input wire        compacted
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_x) && $stable(read_y)
      && $stable(write_index) && $stable(skip_now) && $stable(compacted))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while the first is in progress");

  a_compact_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && compacted |-> skip_now != 32'd0 && read_x == 32'd0 && read_y == 32'd0)
    else $error("compaction reported with zero skip or read data");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {22'd0, write_index} < 32'(ROWS) || ROWS > 1024)
    else $error("write index beyond the store");

endmodule

bind decimating_trace_buffer_core dtb_checker #(.ROWS(ROWS)) u_dtb_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(in_valid),
  .in_stall(in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .read_x(read_x),
  .read_y(read_y),
  .write_index(write_index),
  .skip_now(skip_now),
  .compacted(compacted)
);

`default_nettype wire
